[rtl/sia_pkg.sv]
// Package for the session ID allocator.
// Holds sizes, status and opcode codes, and the control state type.
// No dependencies.
`timescale 1ns / 1ps

package sia_pkg;

    // Number of session IDs, and so of table slots and stack entries.
    localparam int MAX_SESSIONS = 16;

    // Width of an internal ID and of the free-ID count.
    localparam int ID_W  = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SESSIONS + 1);

    // Fixed widths of the channel fields.
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SID_W    = 4;

    // Request opcodes.
    typedef enum logic {
        OP_CONNECT    = 1'b0,
        OP_DISCONNECT = 1'b1
    } sia_op_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_EXISTING = 3'd1,
        ST_FULL     = 3'd2,
        ST_FREED    = 3'd3,
        ST_NOTFOUND = 3'd4
    } sia_status_t;

    // Control states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } sia_state_t;

endpackage

[rtl/sia_req_if.sv]
// Request channel of the session ID allocator: opcode and peer address.
// Depends on sia_pkg for the address width.
`timescale 1ns / 1ps

interface sia_req_if
    import sia_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] peer_address;

    modport source (output valid, output op, output peer_address, input ready);
    modport sink   (input valid, input op, input peer_address, output ready);
endinterface

[rtl/sia_rsp_if.sv]
// Response channel of the session ID allocator: status and session ID.
// Depends on sia_pkg for the field widths.
`timescale 1ns / 1ps

interface sia_rsp_if
    import sia_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SID_W-1:0]    session_id;

    modport source (output valid, output status, output session_id, input ready);
    modport sink   (input valid, input status, input session_id, output ready);
endinterface

[rtl/sia_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       q
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] q_reg;

    // Write port and registered read port; the read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem_reg[raddr];
        end
    end

    assign q = q_reg;

endmodule

[rtl/session_id_allocator.sv]
// Session ID allocator: peer address table with a LIFO stack of free IDs.
// Depends on sia_pkg, sia_req_if, sia_rsp_if and sia_ram.
//
// Usage:
//   The req channel carries one transfer per request: op (connect or
//   disconnect) and a 32-bit peer address. The rsp channel returns exactly
//   one transfer per request: a status code and a 4-bit session ID.
//   Bound addresses live in a slot RAM that is scanned one entry per cycle,
//   lowest ID first; the scan stops at the first match. Free IDs live in a
//   stack RAM whose top is read when the request is taken.
//   A request is taken in S_IDLE, which reads the stack top; S_SCAN reads
//   one slot at a time and compares the slot read before it; S_DECIDE
//   commits. The slot scan sets the response time, so a match ends early.
//   Throughput: one request at a time; a new request is taken in the cycle
//   after the previous one is committed, so requests never overlap.
//   The response sits in an output register, so a new request is taken
//   while an earlier response still waits. If the receiver stalls, the
//   block waits before committing the next request until the register frees.
//   Reset: all slots unbound, the stack holds every ID with the highest on
//   top. No clearing pass is needed; the block is ready after reset.
`timescale 1ns / 1ps

module session_id_allocator
    import sia_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sia_req_if.sink         req,
    sia_rsp_if.source       rsp
);

    localparam logic [ID_W-1:0] LAST_ID = ID_W'(MAX_SESSIONS - 1);

    sia_state_t state_reg, state_next;

    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ID_W-1:0]   scan_idx_reg, scan_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [ID_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic              hit_reg, hit_next;
    logic [ID_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [ID_W-1:0]   top_idx_reg, top_idx_next;

    logic [MAX_SESSIONS-1:0] slot_valid_reg, slot_valid_next;
    logic [MAX_SESSIONS-1:0] stk_written_reg, stk_written_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    sia_status_t         out_status_reg, out_status_next;
    logic [SID_W-1:0]    out_sid_reg, out_sid_next;

    // RAM controls.
    logic              slot_we, slot_re;
    logic [ID_W-1:0]   slot_waddr, slot_raddr;
    logic [ADDR_W-1:0] slot_q;
    logic              stk_we, stk_re;
    logic [ID_W-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_q;

    // Decision helpers.
    logic            match;
    logic [ID_W-1:0] pop_id;
    logic            commit;

    // Slot address RAM: one address per session ID.
    sia_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_SESSIONS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (addr_reg),
        .re    (slot_re),
        .raddr (slot_raddr),
        .q     (slot_q)
    );

    // Free-ID stack RAM; entries never written read as their own index.
    sia_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_SESSIONS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .q     (stk_q)
    );

    // Compare the slot read last cycle, and resolve the top of the stack.
    assign match  = cmp_vld_reg && slot_valid_reg[cmp_idx_reg] && (slot_q == addr_reg);
    assign pop_id = stk_written_reg[top_idx_reg] ? stk_q : top_idx_reg;
    assign commit = (state_reg == S_DECIDE) && (!out_valid_reg || rsp.ready);

    // Channel outputs.
    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.session_id = out_sid_reg;

    // Next state, RAM accesses and response.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        top_idx_next     = top_idx_reg;
        slot_valid_next  = slot_valid_reg;
        stk_written_next = stk_written_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_sid_next     = out_sid_reg;

        slot_we    = 1'b0;
        slot_waddr = pop_id;
        slot_re    = 1'b0;
        slot_raddr = scan_idx_reg;
        stk_we     = 1'b0;
        stk_waddr  = ID_W'(count_reg);
        stk_wdata  = hit_idx_reg;
        stk_re     = 1'b0;
        stk_raddr  = ID_W'(count_reg - 1'b1);

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the request and fetch the stack top in parallel.
                if (req.valid)
                begin
                    op_next       = req.op;
                    addr_next     = req.peer_address;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    hit_next      = 1'b0;
                    top_idx_next  = ID_W'(count_reg - 1'b1);
                    stk_re        = (count_reg != '0);
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read one slot per cycle and compare the one read the cycle before.
                slot_re      = 1'b1;
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_idx_reg != LAST_ID)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = S_DECIDE;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_ID))
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // Update the table and the stack once the output register is free.
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (op_reg == OP_CONNECT)
                    begin
                        if (hit_reg)
                        begin
                            out_status_next = ST_EXISTING;
                            out_sid_next    = SID_W'(hit_idx_reg);
                        end
                        else if (count_reg == '0)
                        begin
                            out_status_next = ST_FULL;
                            out_sid_next    = '0;
                        end
                        else
                        begin
                            count_next              = count_reg - 1'b1;
                            slot_we                 = 1'b1;
                            slot_valid_next[pop_id] = 1'b1;
                            out_status_next         = ST_GRANTED;
                            out_sid_next            = SID_W'(pop_id);
                        end
                    end
                    else
                    begin
                        if (hit_reg)
                        begin
                            slot_valid_next[hit_idx_reg] = 1'b0;
                            if (count_reg < CNT_W'(MAX_SESSIONS))
                            begin
                                stk_we                                 = 1'b1;
                                stk_written_next[ID_W'(count_reg)]     = 1'b1;
                                count_next                             = count_reg + 1'b1;
                            end
                            out_status_next = ST_FREED;
                            out_sid_next    = SID_W'(hit_idx_reg);
                        end
                        else
                        begin
                            out_status_next = ST_NOTFOUND;
                            out_sid_next    = '0;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            slot_valid_reg  <= '0;
            stk_written_reg <= '0;
            count_reg       <= CNT_W'(MAX_SESSIONS);
            out_valid_reg   <= 1'b0;
            scan_idx_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmp_vld_reg     <= cmp_vld_next;
            hit_reg         <= hit_next;
            slot_valid_reg  <= slot_valid_next;
            stk_written_reg <= stk_written_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            scan_idx_reg    <= scan_idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        top_idx_reg    <= top_idx_next;
        out_status_reg <= out_status_next;
        out_sid_reg    <= out_sid_next;
    end

    // Every ID is either bound to a slot or on the free stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(slot_valid_reg) + int'(count_reg)) == MAX_SESSIONS)
        else $error("bound slots plus free IDs differ from the session count");

    // A granted ID must not already be bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (op_reg == OP_CONNECT) && !hit_reg && (count_reg != '0))
        |-> !slot_valid_reg[pop_id])
        else $error("stack popped an ID that is still bound");

    // A new response appears only from the decision step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !$past(rsp.valid && !rsp.ready)) |-> ($past(state_reg) == S_DECIDE))
        else $error("response produced outside the decision step");

endmodule

[tb/session_id_allocator_test.sv]
// Self-checking testbench for the session ID allocator.
// Depends on sia_pkg, sia_req_if, sia_rsp_if and session_id_allocator.
// Directed and random connect/disconnect traffic, checked against a table model.
`timescale 1ns / 1ps

module session_id_allocator_test;
    import sia_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1325;
    localparam int unsigned POOL_SIZE     = 32;
    localparam int unsigned LONG_HOLD     = 500;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES  = 30;

    // One expected response transfer.
    typedef struct packed {
        sia_status_t         status;
        logic [SID_W-1:0]    session_id;
    } sia_result_t;

    // Tracks the address table and free-ID stack and checks each response in order.
    class session_scoreboard;
        logic [ADDR_W-1:0] bound_addr[MAX_SESSIONS];
        bit                bound[MAX_SESSIONS];
        int unsigned       free_ids[MAX_SESSIONS];
        int unsigned       free_depth;
        sia_result_t       expected_q[$];
        int unsigned       requests;
        int unsigned       responses;
        int unsigned       failures;
        int unsigned       tally[5];

        function new();
            for (int i = 0; i < MAX_SESSIONS; i++)
            begin
                bound[i]      = 1'b0;
                bound_addr[i] = '0;
                free_ids[i]   = i;
            end
            free_depth = MAX_SESSIONS;
            requests   = 0;
            responses  = 0;
            failures   = 0;
            for (int i = 0; i < 5; i++)
            begin
                tally[i] = 0;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Applies an accepted request to the table and queues its outcome.
        function void note_request(sia_op_t op, logic [ADDR_W-1:0] addr);
            int          hit;
            int unsigned id;
            sia_result_t res;
            hit = -1;
            // Lowest matching bound slot wins.
            for (int i = MAX_SESSIONS - 1; i >= 0; i--)
            begin
                if (bound[i] && bound_addr[i] == addr)
                begin
                    hit = i;
                end
            end
            res.session_id = '0;
            if (op == OP_CONNECT)
            begin
                if (hit >= 0)
                begin
                    res.status     = ST_EXISTING;
                    res.session_id = SID_W'(hit);
                end
                else if (free_depth == 0)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    free_depth      = free_depth - 1;
                    id              = free_ids[free_depth];
                    bound_addr[id]  = addr;
                    bound[id]       = 1'b1;
                    res.status      = ST_GRANTED;
                    res.session_id  = SID_W'(id);
                end
            end
            else
            begin
                if (hit >= 0)
                begin
                    bound[hit] = 1'b0;
                    if (free_depth < MAX_SESSIONS)
                    begin
                        free_ids[free_depth] = hit;
                        free_depth           = free_depth + 1;
                    end
                    res.status     = ST_FREED;
                    res.session_id = SID_W'(hit);
                end
                else
                begin
                    res.status = ST_NOTFOUND;
                end
            end
            expected_q.push_back(res);
            requests++;
        endfunction

        // Compares one response transfer with the oldest outstanding outcome.
        function void check_response(logic [STATUS_W-1:0] status, logic [SID_W-1:0] sid);
            sia_result_t want;
            responses++;
            if (expected_q.size() == 0)
            begin
                $error("Response with no request outstanding: status %0d, session_id %0d",
                       status, sid);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            tally[int'(want.status)]++;
            if (status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                failures++;
            end
            if (sid !== want.session_id)
            begin
                $error("session_id mismatch: expected %0d, actual %0d", want.session_id, sid);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sia_req_if req_ch();
    sia_rsp_if rsp_ch();

    session_id_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    session_scoreboard sb;
    logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
    int unsigned       idle_cycles;

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Pool addresses recur so sessions get reused; near misses differ in a single bit.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 88)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
        else
            return $urandom;
    endfunction

    // Offers one request after an idle gap and holds it until the transfer.
    task automatic send_request(input sia_op_t op, input logic [ADDR_W-1:0] addr,
                                input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.peer_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drops valid and waits until every outstanding response has arrived.
    task automatic idle_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Fills the table, hits every status, and exercises the empty stack.
    task automatic run_directed();
        send_request(OP_CONNECT, 32'h0000_0000, 0);
        send_request(OP_CONNECT, 32'hFFFF_FFFF, 0);
        send_request(OP_CONNECT, 32'hFFFF_FFFF, 0);
        send_request(OP_CONNECT, 32'h0000_0000, 2);
        send_request(OP_DISCONNECT, 32'h0000_0000, 0);
        send_request(OP_DISCONNECT, 32'h0000_0000, 0);
        send_request(OP_DISCONNECT, 32'h8000_0000, 1);
        // Walking-one addresses take the remaining fifteen IDs.
        for (int k = 0; k < 15; k++)
        begin
            send_request(OP_CONNECT, 32'h1 << k, 0);
        end
        send_request(OP_CONNECT, 32'h7FFF_FFFF, 0);
        send_request(OP_DISCONNECT, 32'hFFFF_FFFF, 0);
        send_request(OP_CONNECT, 32'h7FFF_FFFF, 0);
    endtask

    // Random traffic in phases that lean toward filling or emptying the table.
    task automatic run_random();
        int unsigned connect_pct;
        bit          calm;
        sia_op_t     op;
        connect_pct = 50;
        calm        = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ((n / 50) % 4)
                    0: connect_pct = 75;
                    1: connect_pct = 50;
                    2: connect_pct = 25;
                    default: connect_pct = 60;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n == 700)
            begin
                idle_until_drained();
            end
            op = ($urandom_range(0, 99) < connect_pct) ? OP_CONNECT : OP_DISCONNECT;
            send_request(op, pick_address(), calm ? 0 : pick_gap());
        end
    endtask

    // Main sequence: reset, stimulus, drain, verdict.
    initial
    begin
        sb                  = new();
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_CONNECT;
        req_ch.peer_address = '0;
        for (int k = 0; k < 15; k++)
        begin
            addr_pool[k] = 32'h1 << k;
        end
        addr_pool[15] = 32'h7FFF_FFFF;
        addr_pool[16] = 32'hFFFF_FFFF;
        addr_pool[17] = 32'h0000_0000;
        for (int k = 18; k < POOL_SIZE; k++)
        begin
            addr_pool[k] = $urandom;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d granted, %0d existing, %0d refused, %0d freed,",
                 sb.requests, sb.tally[ST_GRANTED], sb.tally[ST_EXISTING],
                 sb.tally[ST_FULL], sb.tally[ST_FREED]);
        $display("%0d not found; one receiver stall of %0d cycles and one full drain.",
                 sb.tally[ST_NOTFOUND], LONG_HOLD);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, calm stretches, and one long stall that backs up the block.
    initial
    begin
        int unsigned hold;
        int unsigned calm_left;
        bit          calm;
        bit          long_done;
        hold         = 0;
        calm_left    = 100;
        calm         = 1'b0;
        long_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_done && sb.responses >= 400)
            begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
            end
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 200);
            end
            else
            begin
                calm_left--;
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm)
                    hold = pick_gap();
            end
        end
    end

    // Monitor: every transfer on either channel goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(sia_op_t'(req_ch.op), req_ch.peer_address);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.session_id);
        end
    end

    // Watchdog: ends the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
